@@ design/rps_pkg.sv @@
// Shared types, register decode and color-step function for the rainbow pixel sequencer.
`default_nettype none

package rps_pkg;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} color_t;

	// Configuration register index, taken from paddr[2]
	localparam logic REG_BRIGHT_LIMIT = 1'b0;
	localparam logic REG_PIXEL_COUNT  = 1'b1;

	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned POS_W  = 10;
	localparam int unsigned LVL_W  = 6;

	localparam logic [7:0]       LIMIT_RST = 8'd255;
	localparam logic [POS_W-1:0] COUNT_RST = 10'd93;

	// Color wheel phases
	localparam logic [2:0] PH_GREEN_UP   = 3'd0;
	localparam logic [2:0] PH_RED_DOWN   = 3'd1;
	localparam logic [2:0] PH_BLUE_UP    = 3'd2;
	localparam logic [2:0] PH_GREEN_DOWN = 3'd3;
	localparam logic [2:0] PH_RED_UP     = 3'd4;
	localparam logic [2:0] PH_BLUE_DOWN  = 3'd5;

	typedef struct packed {
		color_t     color;
		logic [2:0] phase;
	} wheel_t;

	// One step of the wheel; unused phases hold color and phase.
	function automatic wheel_t wheel_step(input wheel_t cur, input logic [7:0] peak);
		wheel_t nxt;
		nxt = cur;
		case (cur.phase)
			PH_GREEN_UP: begin
				nxt.color.g = cur.color.g + 8'd1;
				if (nxt.color.g >= peak) nxt.phase = PH_RED_DOWN;
			end
			PH_RED_DOWN: begin
				nxt.color.r = cur.color.r - 8'd1;
				if (nxt.color.r == 8'd0) nxt.phase = PH_BLUE_UP;
			end
			PH_BLUE_UP: begin
				nxt.color.b = cur.color.b + 8'd1;
				if (nxt.color.b >= peak) nxt.phase = PH_GREEN_DOWN;
			end
			PH_GREEN_DOWN: begin
				nxt.color.g = cur.color.g - 8'd1;
				if (nxt.color.g == 8'd0) nxt.phase = PH_RED_UP;
			end
			PH_RED_UP: begin
				nxt.color.r = cur.color.r + 8'd1;
				if (nxt.color.r >= peak) nxt.phase = PH_BLUE_DOWN;
			end
			PH_BLUE_DOWN: begin
				nxt.color.b = cur.color.b - 8'd1;
				if (nxt.color.b == 8'd0) nxt.phase = PH_GREEN_UP;
			end
			default: begin
				nxt = cur;
			end
		endcase
		return nxt;
	endfunction

endpackage

`default_nettype wire

@@ design/rainbow_pixel_sequencer_unit.sv @@
// Rainbow pixel sequencer: one rainbow pixel per input transfer, last pixel of frame flagged.
// The result of each input transfer is registered straight into the output register.
// Throughput: one pixel per cycle unless the output stalls; the wheel step, frame-start capture
// and position update are one short combinational pass into the state and output registers.
// Reset: wheel and frame start return to full red (254) at phase 0, pixel 0;
// bright_limit resets to 255, pixel_count to 93, and the output register empties.
`default_nettype none

module rainbow_pixel_sequencer_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration port
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [rps_pkg::ADDR_W-1:0]        paddr,
	input  wire logic [rps_pkg::DATA_W-1:0]        pwdata,
	output logic      [rps_pkg::DATA_W-1:0]        prdata,
	output logic                                   pready,
	// input channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              restart,
	// output channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [rps_pkg::LVL_W-1:0]         red,
	output logic      [rps_pkg::LVL_W-1:0]         green,
	output logic      [rps_pkg::LVL_W-1:0]         blue,
	output logic      [rps_pkg::POS_W-1:0]         pixel_index,
	output logic                                   last_in_frame
);

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [7:0]                  bright_limit_q;
	logic [rps_pkg::POS_W-1:0]   pixel_count_q;
	logic                        cfg_wr;
	logic                        cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_limit_q <= rps_pkg::LIMIT_RST;
			pixel_count_q  <= rps_pkg::COUNT_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				rps_pkg::REG_BRIGHT_LIMIT: bright_limit_q <= pwdata[7:0];
				rps_pkg::REG_PIXEL_COUNT:  pixel_count_q  <= pwdata[rps_pkg::POS_W-1:0];
				default:                   bright_limit_q <= bright_limit_q;
			endcase
		end
	end

	// Read back the addressed register, zero-extended
	always_comb begin
		case (cfg_idx)
			rps_pkg::REG_BRIGHT_LIMIT:
				prdata = {{(rps_pkg::DATA_W-8){1'b0}}, bright_limit_q};
			rps_pkg::REG_PIXEL_COUNT:
				prdata = {{(rps_pkg::DATA_W-rps_pkg::POS_W){1'b0}}, pixel_count_q};
			default:
				prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Handshake: the output register parts the two sides. Take a new
	// transfer whenever the output register is empty or is being drained.
	// ---------------------------------------------------------------
	logic out_valid_q;
	logic in_acc;

	assign in_stall  = out_valid_q & out_stall;
	assign in_acc    = in_valid & ~in_stall;
	assign out_valid = out_valid_q;

	// ---------------------------------------------------------------
	// Animation state
	// ---------------------------------------------------------------
	rps_pkg::wheel_t             cur_q;
	rps_pkg::wheel_t             fs_q;
	logic [rps_pkg::POS_W-1:0]   pixel_pos_q;

	logic [7:0]                  peak;
	rps_pkg::wheel_t             red_start;
	rps_pkg::wheel_t             cur_eff;
	rps_pkg::wheel_t             fs_eff;
	rps_pkg::wheel_t             fs_nxt;
	rps_pkg::wheel_t             stepped;
	logic [rps_pkg::POS_W-1:0]   pos_eff;
	logic [rps_pkg::POS_W-1:0]   last_pos;
	logic                        last_c;

	// Peak wraps at 8 bits, so limits of 0 and 1 give 255 and 0
	assign peak = bright_limit_q - 8'd1;

	always_comb begin
		red_start.color.r = peak;
		red_start.color.g = 8'd0;
		red_start.color.b = 8'd0;
		red_start.phase   = rps_pkg::PH_GREEN_UP;
	end

	// Restart wipes current wheel, frame start and position before the pixel goes out
	assign cur_eff = restart ? red_start : cur_q;
	assign fs_eff  = restart ? red_start : fs_q;
	assign pos_eff = restart ? '0 : pixel_pos_q;

	// Frames of zero or one pixel behave as one-pixel frames; a count lowered
	// mid-frame ends the frame at once.
	assign last_pos = (pixel_count_q < rps_pkg::POS_W'(2)) ? '0
	                                                         : pixel_count_q - rps_pkg::POS_W'(1);
	assign last_c   = (pos_eff >= last_pos);

	// Capture the second pixel's wheel as the next frame's starting point
	assign fs_nxt  = (pos_eff == rps_pkg::POS_W'(1)) ? cur_eff : fs_eff;
	assign stepped = rps_pkg::wheel_step(cur_eff, peak);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.color.r <= rps_pkg::LIMIT_RST - 8'd1;
			cur_q.color.g <= 8'd0;
			cur_q.color.b <= 8'd0;
			cur_q.phase   <= rps_pkg::PH_GREEN_UP;
			fs_q.color.r  <= rps_pkg::LIMIT_RST - 8'd1;
			fs_q.color.g  <= 8'd0;
			fs_q.color.b  <= 8'd0;
			fs_q.phase    <= rps_pkg::PH_GREEN_UP;
			pixel_pos_q   <= '0;
		end else if (in_acc) begin
			fs_q <= fs_nxt;
			if (last_c) begin
				// Frame done: rewind to the drifted start
				cur_q       <= fs_nxt;
				pixel_pos_q <= '0;
			end else begin
				cur_q       <= stepped;
				pixel_pos_q <= pos_eff + rps_pkg::POS_W'(1);
			end
		end
	end

	// ---------------------------------------------------------------
	// Output register: the pixel is the wheel before its step, each
	// channel divided by four.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			red           <= cur_eff.color.r[7:2];
			green         <= cur_eff.color.g[7:2];
			blue          <= cur_eff.color.b[7:2];
			pixel_index   <= pos_eff;
			last_in_frame <= last_c;
		end
	end

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	// A transfer on the input always fills the output register
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid_q)
		else $error("output register not loaded after input transfer");

	// Input holds off only behind a stalled, full output register
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q)
		else $error("input stalled with empty output register");

	// The last pixel of a frame rewinds the position
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last_c) |=> (pixel_pos_q == '0))
		else $error("pixel position did not rewind after last pixel");

	// Wheel phase never leaves the six used phases
	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q.phase <= rps_pkg::PH_BLUE_DOWN) && (fs_q.phase <= rps_pkg::PH_BLUE_DOWN))
		else $error("wheel phase out of range");

endmodule

`default_nettype wire

@@ test/rps_checker.sv @@
// Checker for the rainbow pixel sequencer: predicts every pixel and compares the output.
`timescale 1ns / 1ps

module rps_stream_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [rps_pkg::ADDR_W-1:0] paddr,
	input  wire logic [rps_pkg::DATA_W-1:0] pwdata,
	input  wire logic                       pready,
	input  wire logic                       in_valid,
	input  wire logic                       in_stall,
	input  wire logic                       restart,
	input  wire logic                       out_valid,
	input  wire logic                       out_stall,
	input  wire logic [rps_pkg::LVL_W-1:0]  red,
	input  wire logic [rps_pkg::LVL_W-1:0]  green,
	input  wire logic [rps_pkg::LVL_W-1:0]  blue,
	input  wire logic [rps_pkg::POS_W-1:0]  pixel_index,
	input  wire logic                       last_in_frame,
	output int                              fail_count,
	output int                              pending,
	output int                              frame_total,
	output int                              restart_total
);

	typedef struct packed {
		logic [rps_pkg::LVL_W-1:0] red;
		logic [rps_pkg::LVL_W-1:0] green;
		logic [rps_pkg::LVL_W-1:0] blue;
		logic [rps_pkg::POS_W-1:0] index;
		logic                      last;
	} pixel_t;

	logic [7:0]                bright_limit;
	logic [rps_pkg::POS_W-1:0] pixel_count;
	rps_pkg::color_t           wheel_color;
	rps_pkg::color_t           start_color;
	logic [2:0]                wheel_phase;
	logic [2:0]                start_phase;
	logic [rps_pkg::POS_W-1:0] pixel_pos;
	pixel_t                    expected_pixels[$];

	// Return wheel and frame start to full red, phase 0, pixel 0
	task automatic load_full_red();
		logic [7:0] peak;
		peak = bright_limit - 8'd1;
		wheel_color = {peak, 8'd0, 8'd0};
		start_color = wheel_color;
		wheel_phase = rps_pkg::PH_GREEN_UP;
		start_phase = rps_pkg::PH_GREEN_UP;
		pixel_pos = '0;
	endtask

	// Emit the pixel for one input transfer and step the wheel
	task automatic predict_pixel(input logic restart_bit, output pixel_t px);
		logic [7:0]                peak;
		logic [rps_pkg::POS_W-1:0] end_pos;
		logic                      at_end;
		if (restart_bit) load_full_red();
		peak = bright_limit - 8'd1;
		end_pos = (pixel_count < 2) ? '0 : pixel_count - 1'b1;
		// a count lowered mid-frame closes the frame at once
		at_end = (pixel_pos >= end_pos);
		px.red = wheel_color.r[7:2];
		px.green = wheel_color.g[7:2];
		px.blue = wheel_color.b[7:2];
		px.index = pixel_pos;
		px.last = at_end;
		// the second pixel decides where the next frame starts
		if (pixel_pos == 1) begin
			start_color = wheel_color;
			start_phase = wheel_phase;
		end
		case (wheel_phase)
			rps_pkg::PH_GREEN_UP: begin
				wheel_color.g = wheel_color.g + 8'd1;
				if (wheel_color.g >= peak) wheel_phase = rps_pkg::PH_RED_DOWN;
			end
			rps_pkg::PH_RED_DOWN: begin
				wheel_color.r = wheel_color.r - 8'd1;
				if (wheel_color.r == 8'd0) wheel_phase = rps_pkg::PH_BLUE_UP;
			end
			rps_pkg::PH_BLUE_UP: begin
				wheel_color.b = wheel_color.b + 8'd1;
				if (wheel_color.b >= peak) wheel_phase = rps_pkg::PH_GREEN_DOWN;
			end
			rps_pkg::PH_GREEN_DOWN: begin
				wheel_color.g = wheel_color.g - 8'd1;
				if (wheel_color.g == 8'd0) wheel_phase = rps_pkg::PH_RED_UP;
			end
			rps_pkg::PH_RED_UP: begin
				wheel_color.r = wheel_color.r + 8'd1;
				if (wheel_color.r >= peak) wheel_phase = rps_pkg::PH_BLUE_DOWN;
			end
			rps_pkg::PH_BLUE_DOWN: begin
				wheel_color.b = wheel_color.b - 8'd1;
				if (wheel_color.b == 8'd0) wheel_phase = rps_pkg::PH_GREEN_UP;
			end
			default: ;
		endcase
		if (at_end) begin
			pixel_pos = '0;
			wheel_color = start_color;
			wheel_phase = start_phase;
		end else begin
			pixel_pos = pixel_pos + 1'b1;
		end
	endtask

	task automatic check_field(input string name, input logic [rps_pkg::POS_W-1:0] want,
			input logic [rps_pkg::POS_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= 200) $error("%s mismatch: expected %0d, got %0d", name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		pixel_t seen;
		if (!arst_n) begin
			bright_limit = rps_pkg::LIMIT_RST;
			pixel_count = rps_pkg::COUNT_RST;
			load_full_red();
			expected_pixels.delete();
			fail_count = 0;
			pending = 0;
			frame_total = 0;
			restart_total = 0;
		end else begin
			if (in_valid && !in_stall) begin
				if (restart) restart_total++;
				predict_pixel(restart, want);
				expected_pixels.push_back(want);
			end
			if (out_valid && !out_stall) begin
				seen = {red, green, blue, pixel_index, last_in_frame};
				if (seen.last) frame_total++;
				if (expected_pixels.size() == 0) begin
					fail_count++;
					if (fail_count <= 200) $error("pixel out with no transfer pending");
				end else begin
					want = expected_pixels.pop_front();
					check_field("red", rps_pkg::POS_W'(want.red), rps_pkg::POS_W'(seen.red));
					check_field("green", rps_pkg::POS_W'(want.green),
						rps_pkg::POS_W'(seen.green));
					check_field("blue", rps_pkg::POS_W'(want.blue), rps_pkg::POS_W'(seen.blue));
					check_field("pixel_index", want.index, seen.index);
					check_field("last_in_frame", rps_pkg::POS_W'(want.last),
						rps_pkg::POS_W'(seen.last));
				end
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == rps_pkg::REG_PIXEL_COUNT) pixel_count = pwdata[rps_pkg::POS_W-1:0];
				else bright_limit = pwdata[7:0];
			end
			pending = expected_pixels.size();
		end
	end

endmodule

@@ test/tb.sv @@
// Top of the rainbow pixel sequencer testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb;

	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned CHOKE_CYCLES = 200;
	localparam int          RANDOM_ITEMS = 60;
	localparam logic [rps_pkg::ADDR_W-1:0] ADDR_LIMIT = {rps_pkg::REG_BRIGHT_LIMIT, 2'b00};
	localparam logic [rps_pkg::ADDR_W-1:0] ADDR_COUNT = {rps_pkg::REG_PIXEL_COUNT, 2'b00};

	logic                       clk;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [rps_pkg::ADDR_W-1:0] paddr;
	logic [rps_pkg::DATA_W-1:0] pwdata;
	logic [rps_pkg::DATA_W-1:0] prdata;
	logic                       pready;
	logic                       in_valid;
	logic                       in_stall;
	logic                       restart;
	logic                       out_valid;
	logic                       out_stall;
	logic [rps_pkg::LVL_W-1:0]  red;
	logic [rps_pkg::LVL_W-1:0]  green;
	logic [rps_pkg::LVL_W-1:0]  blue;
	logic [rps_pkg::POS_W-1:0]  pixel_index;
	logic                       last_in_frame;

	int          fail_count;
	int          pending;
	int          frame_total;
	int          restart_total;
	int unsigned cycle_count = 0;
	int          items_sent = 0;
	int          settings_applied = 0;
	bit          steady = 1'b0;     // no random idling on either side while set
	bit          choke_req = 1'b0;  // receiver clears this when its long hold-off begins

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	rainbow_pixel_sequencer_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.pixel_index(pixel_index),
		.last_in_frame(last_in_frame)
	);

	rps_stream_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.pixel_index(pixel_index),
		.last_in_frame(last_in_frame),
		.fail_count(fail_count),
		.pending(pending),
		.frame_total(frame_total),
		.restart_total(restart_total)
	);

	// Idle length for either side: mostly none, often short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(99);
		if (steady || roll < 55) return 0;
		if (roll < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 4);
	endfunction

	// Offer n pixel transfers; restart_pct is the chance in percent of a restart on each.
	// Valid stays high straight into the next transfer when no gap is drawn.
	task automatic feed(input int n, input int unsigned restart_pct);
		int unsigned idle;
		for (int k = 0; k < n; k++) begin
			in_valid <= 1'b1;
			restart <= ($urandom_range(99) < restart_pct);
			@(posedge clk);
			while (in_stall) @(posedge clk);
			items_sent++;
			idle = pick_gap();
			if (idle != 0) begin
				in_valid <= 1'b0;
				repeat (idle) @(posedge clk);
			end
		end
	endtask

	// Drop valid, wait until every predicted pixel is back, then cover the latency
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write: setup cycle, access cycle, release. Upper data bits carry noise.
	task automatic write_reg(input logic [rps_pkg::ADDR_W-1:0] addr,
			input logic [rps_pkg::POS_W-1:0] field);
		logic [rps_pkg::DATA_W-1:0] value;
		value = $urandom();
		value[rps_pkg::POS_W-1:0] = field;
		if (addr == ADDR_LIMIT) value[rps_pkg::POS_W-1:8] = '0;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		settings_applied++;
	endtask

	// Receiver: random stalls, plus one long hold-off whenever the sender asks
	initial begin
		int unsigned hold;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (choke_req) begin
				choke_req = 1'b0;
				out_stall <= 1'b1;
				repeat (CHOKE_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				hold = pick_gap();
				if (hold != 0) begin
					out_stall <= 1'b1;
					repeat (hold) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// Hard stop if the run hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int                        random_goal;
		int unsigned               roll;
		int unsigned               rate;
		logic [7:0]                lim;
		logic [rps_pkg::POS_W-1:0] cnt;
		bit                        first_phase;

		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		restart <= 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// Reset setting: full red, 93-pixel frames
		feed(3, 0);
		drain();

		// Two-pixel frames at the top brightness, after a restart
		write_reg(ADDR_LIMIT, 10'd255);
		write_reg(ADDR_COUNT, 10'd2);
		feed(1, 100);
		feed(4, 0);
		drain();

		// One-pixel frames: every pixel last, no drift
		write_reg(ADDR_COUNT, 10'd1);
		feed(2, 0);
		drain();
		write_reg(ADDR_COUNT, 10'd0);
		feed(2, 0);
		drain();

		// Restart picks up the new brightness limit
		write_reg(ADDR_LIMIT, 10'd2);
		write_reg(ADDR_COUNT, 10'd3);
		feed(1, 100);
		feed(4, 0);
		drain();

		// Peak wraps to zero and to 255
		write_reg(ADDR_LIMIT, 10'd1);
		feed(1, 100);
		feed(2, 0);
		drain();
		write_reg(ADDR_LIMIT, 10'd0);
		feed(1, 100);
		feed(2, 0);
		drain();

		// Shrink the frame while the position is past the new end
		write_reg(ADDR_LIMIT, 10'd6);
		write_reg(ADDR_COUNT, 10'd12);
		feed(6, 0);
		drain();
		write_reg(ADDR_COUNT, 10'd3);
		feed(2, 0);
		drain();

		// One full-length frame to reach the top pixel index
		write_reg(ADDR_LIMIT, rps_pkg::POS_W'($urandom_range(255, 0)));
		write_reg(ADDR_COUNT, 10'd1023);
		feed(1, 100);
		feed(1022, 0);
		drain();

		// Random phases: mostly long restart-free runs with small limits so the
		// wheel drifts through all six phases; registers change between phases
		random_goal = items_sent + RANDOM_ITEMS;
		first_phase = 1'b1;
		while (items_sent < random_goal) begin
			roll = $urandom_range(99);
			if (roll < 50) lim = 8'($urandom_range(16, 2));
			else if (roll < 75) lim = 8'($urandom_range(255, 0));
			else begin
				case ($urandom_range(3))
					0: lim = 8'd0;
					1: lim = 8'd1;
					2: lim = 8'd2;
					default: lim = 8'd255;
				endcase
			end
			roll = $urandom_range(99);
			if (roll < 55) cnt = rps_pkg::POS_W'($urandom_range(12, 2));
			else if (roll < 80) cnt = rps_pkg::POS_W'($urandom_range(100, 13));
			else if (roll < 90) cnt = rps_pkg::POS_W'($urandom_range(1, 0));
			else cnt = rps_pkg::POS_W'($urandom_range(300, 101));
			// leave a register alone now and then so position and wheel carry over
			if ($urandom_range(9) < 7) write_reg(ADDR_LIMIT, rps_pkg::POS_W'(lim));
			if ($urandom_range(9) < 7) write_reg(ADDR_COUNT, cnt);

			steady = ($urandom_range(4) == 0);
			if (first_phase || $urandom_range(14) == 0) begin
				// back up the block: receiver holds off while the sender keeps offering
				steady = 1'b1;
				choke_req = 1'b1;
				while (choke_req) @(posedge clk);
			end
			first_phase = 1'b0;
			rate = ($urandom_range(5) == 0) ? 20 : $urandom_range(3);
			feed($urandom_range(60, 15), rate);
			drain();
			steady = 1'b0;
		end

		drain();
		repeat (10) @(posedge clk);
		$display("Covered %0d pixel transfers, %0d restarts and %0d frame ends",
			items_sent, restart_total, frame_total);
		$display("over %0d register writes, including one-pixel, shrunk and full-length frames %s",
			settings_applied, "and wrapped brightness limits.");
		if (fail_count == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule

@@ files.f @@
design/rps_pkg.sv
design/rainbow_pixel_sequencer_unit.sv
test/rps_checker.sv
test/tb.sv
